FILE: hdl/refcounted_buffer_slot_manager_unit_defines.svh
// ============================================================================
// Buffer slot manager assertion macros
// Shared property wrappers for the slot manager checks.
// ============================================================================
`ifndef REFCOUNTED_BUFFER_SLOT_MANAGER_UNIT_DEFINES_SVH
`define REFCOUNTED_BUFFER_SLOT_MANAGER_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define RBSM_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define RBSM_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: hdl/rbsm_pkg.sv
// ============================================================================
// Buffer slot manager package
// Sizes, slot entry layout, action and status codes, and the FSM state encoding.
// ============================================================================
`default_nettype none

package rbsm_pkg;

    localparam int SLOTS        = 32;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int HEADER_BYTES = 64;
    localparam int HANDLE_W     = 6;
    localparam int TYPE_W       = 16;
    localparam int DATA_W       = 24;
    localparam int TOTAL_W      = 25;
    localparam int USERS_W      = 16;
    localparam int BYTES_W      = 32;

    localparam logic [HANDLE_W-1:0] NO_SLOT = '1;
    localparam logic [USERS_W-1:0]  USERS_MAX = '1;

    typedef struct packed {
        logic [TYPE_W-1:0]  btype;
        logic [TOTAL_W-1:0] total;
        logic [USERS_W-1:0] users;
        logic               passing;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    localparam logic [3:0] ACT_NEW        = 4'd0;
    localparam logic [3:0] ACT_BRANDNEW   = 4'd1;
    localparam logic [3:0] ACT_COPY_RO    = 4'd2;
    localparam logic [3:0] ACT_COPY_RW    = 4'd3;
    localparam logic [3:0] ACT_CLONE      = 4'd4;
    localparam logic [3:0] ACT_UNUSED     = 4'd5;
    localparam logic [3:0] ACT_DELETE     = 4'd6;
    localparam logic [3:0] ACT_MARK_PASS  = 4'd7;
    localparam logic [3:0] ACT_UNMARK     = 4'd8;
    localparam logic [3:0] ACT_COLLECT    = 4'd9;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_HANDLE  = 4'd1;
    localparam logic [3:0] ST_ZERO_USERS  = 4'd2;
    localparam logic [3:0] ST_NO_MEMORY   = 4'd3;
    localparam logic [3:0] ST_PASS_IGN    = 4'd4;
    localparam logic [3:0] ST_DUP_PASS    = 4'd5;
    localparam logic [3:0] ST_NOT_EXCL    = 4'd6;
    localparam logic [3:0] ST_USERS_LEFT  = 4'd7;
    localparam logic [3:0] ST_SATURATED   = 4'd8;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_HRD    = 14'b00000000000010,
        S_HEV    = 14'b00000000000100,
        S_R_RD   = 14'b00000000001000,
        S_R_EV   = 14'b00000000010000,
        S_EMPTY  = 14'b00000000100000,
        S_E_RD   = 14'b00000001000000,
        S_E_EV   = 14'b00000010000000,
        S_E_FIT  = 14'b00000100000000,
        S_COL_RD = 14'b00001000000000,
        S_COL_EV = 14'b00010000000000,
        S_AFF_RD = 14'b00100000000000,
        S_AFF_EV = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/refcounted_buffer_slot_manager_unit.sv
// Handle actions read the addressed slot; an allocation scans the slot table in up to
// three passes (reuse, empty, eviction), and collect reads each occupied slot.
// Throughput: one item at a time; a new item is taken only in the idle state.
// Reset: all slots empty, byte count and live count zero, byte limit all ones.
// ============================================================================
// Buffer slot manager
// Reference-counted buffer slot pool with a byte budget and eviction.
// ============================================================================
`default_nettype none
`include "refcounted_buffer_slot_manager_unit_defines.svh"

module refcounted_buffer_slot_manager_unit
    import rbsm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_limit_we,
    input  wire logic [BYTES_W-1:0]  byte_limit,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [3:0]          action,
    input  wire logic [HANDLE_W-1:0] handle,
    input  wire logic [TYPE_W-1:0]   buffer_type,
    input  wire logic [DATA_W-1:0]   data_bytes,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [3:0]               status,
    output logic [HANDLE_W-1:0]      result_handle,
    output logic [USERS_W-1:0]       users_left,
    output logic                     writable,
    output logic                     owner_released,
    output logic [HANDLE_W-1:0]      copy_from,
    output logic [5:0]               freed_count,
    output logic [BYTES_W-1:0]       bytes_in_use,
    output logic [5:0]               live_buffers
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [3:0]           act_reg, act_next;
    logic [HANDLE_W-1:0]  h_reg, h_next;
    logic [TYPE_W-1:0]    al_type_reg, al_type_next;
    logic [TOTAL_W-1:0]   al_total_reg, al_total_next;
    logic                 is_copy_reg, is_copy_next;
    logic [3:0]           st_reg, st_next;
    logic [HANDLE_W-1:0]  res_reg, res_next;
    logic [5:0]           freed_reg, freed_next;
    logic                 rel_reg, rel_next;
    logic [USERS_W-1:0]   users_reg, users_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic [SLOTS-1:0]     occ_reg, occ_next;
    logic [BYTES_W-1:0]   limit_reg;

    logic                 ram_we, ram_re;
    logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
    slot_entry_t          ram_wdata, rd;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 h_in_range, h_valid;
    logic [SLOT_W-1:0]    hidx, cur, down;
    logic [CNT_W-1:0]     idx_dn;
    logic [BYTES_W:0]     sum, cap;
    logic                 fits;
    logic [USERS_W-1:0]   dec_users;
    logic [HANDLE_W-1:0]  aff;

    rbsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd = slot_entry_t'(ram_rdata);

    assign h_in_range = (h_reg[HANDLE_W-1] == 1'b0) &&
                        ({1'b0, h_reg[HANDLE_W-2:0]} < HANDLE_W'(SLOTS));
    assign hidx    = h_reg[SLOT_W-1:0];
    assign h_valid = h_in_range && occ_reg[hidx];
    assign cur     = idx_reg[SLOT_W-1:0];
    assign idx_dn  = idx_reg - CNT_W'(1);
    assign down    = idx_dn[SLOT_W-1:0];

    assign sum  = {1'b0, bytes_reg} + (BYTES_W+1)'(al_total_reg);
    assign cap  = (limit_reg == '0) ? {1'b0, {BYTES_W{1'b1}}} : {1'b0, limit_reg};
    assign fits = (sum <= cap);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        act_next      = act_reg;
        h_next        = h_reg;
        al_type_next  = al_type_reg;
        al_total_next = al_total_reg;
        is_copy_next  = is_copy_reg;
        st_next       = st_reg;
        res_next      = res_reg;
        freed_next    = freed_reg;
        rel_next      = rel_reg;
        users_next    = users_reg;
        bytes_next    = bytes_reg;
        live_next     = live_reg;
        occ_next      = occ_reg;
        ram_we        = 1'b0;
        ram_waddr     = cur;
        ram_wdata     = '{btype: al_type_reg, total: al_total_reg,
                          users: USERS_W'(1), passing: 1'b0};
        ram_re        = 1'b0;
        ram_raddr     = cur;
        dec_users     = rd.users;
        aff           = NO_SLOT;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action;
                    h_next        = handle;
                    al_type_next  = buffer_type;
                    al_total_next = TOTAL_W'(data_bytes) + TOTAL_W'(HEADER_BYTES);
                    is_copy_next  = 1'b0;
                    st_next       = ST_OK;
                    res_next      = NO_SLOT;
                    freed_next    = '0;
                    rel_next      = 1'b0;
                    idx_next      = '0;
                    if (action == ACT_NEW)
                    begin
                        state_next = S_R_RD;
                    end
                    else if (action == ACT_BRANDNEW)
                    begin
                        state_next = S_EMPTY;
                    end
                    else if (action == ACT_COLLECT)
                    begin
                        state_next = S_COL_RD;
                    end
                    else
                    begin
                        state_next = S_HRD;
                    end
                end
            end

            S_HRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = hidx;
                state_next = S_HEV;
                if (act_reg > ACT_COLLECT)
                begin
                    state_next = S_AFF_RD;
                end
                else if (!h_valid)
                begin
                    if ((act_reg == ACT_UNUSED || act_reg == ACT_DELETE) && h_reg == NO_SLOT)
                    begin
                        st_next = ST_OK;
                    end
                    else
                    begin
                        st_next = ST_BAD_HANDLE;
                    end
                    state_next = S_AFF_RD;
                end
            end

            S_HEV:
            begin
                ram_waddr  = hidx;
                ram_wdata  = rd;
                state_next = S_AFF_RD;
                case (act_reg)
                    ACT_COPY_RO, ACT_COPY_RW:
                    begin
                        if (rd.users == '0)
                        begin
                            st_next = ST_ZERO_USERS;
                        end
                        else if (rd.passing)
                        begin
                            ram_we            = 1'b1;
                            ram_wdata.passing = 1'b0;
                            rel_next          = 1'b1;
                            res_next          = h_reg;
                        end
                        else if (act_reg == ACT_COPY_RO)
                        begin
                            if (rd.users == USERS_MAX)
                            begin
                                st_next = ST_SATURATED;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_wdata.users = rd.users + USERS_W'(1);
                                res_next        = h_reg;
                            end
                        end
                        else
                        begin
                            al_type_next  = rd.btype;
                            al_total_next = rd.total;
                            is_copy_next  = 1'b1;
                            idx_next      = '0;
                            state_next    = S_R_RD;
                        end
                    end
                    ACT_CLONE:
                    begin
                        al_type_next  = rd.btype;
                        al_total_next = rd.total;
                        idx_next      = '0;
                        state_next    = S_R_RD;
                    end
                    ACT_UNUSED, ACT_DELETE:
                    begin
                        if (rd.passing)
                        begin
                            st_next = ST_PASS_IGN;
                        end
                        else if (rd.users == '0)
                        begin
                            st_next = ST_ZERO_USERS;
                        end
                        else
                        begin
                            dec_users = rd.users - USERS_W'(1);
                        end
                        ram_wdata.users = dec_users;
                        if (act_reg == ACT_UNUSED)
                        begin
                            if (!rd.passing && rd.users != '0)
                            begin
                                ram_we   = 1'b1;
                                res_next = h_reg;
                            end
                        end
                        else if (dec_users == '0)
                        begin
                            // The slot goes away, so its entry needs no update.
                            bytes_next     = bytes_reg - BYTES_W'(rd.total);
                            live_next      = live_reg - CNT_W'(1);
                            occ_next[hidx] = 1'b0;
                            freed_next     = 6'd1;
                            st_next        = ST_OK;
                        end
                        else
                        begin
                            ram_we  = 1'b1;
                            st_next = ST_USERS_LEFT;
                        end
                    end
                    ACT_MARK_PASS:
                    begin
                        if (rd.passing)
                        begin
                            st_next = ST_DUP_PASS;
                        end
                        else if (rd.users != USERS_W'(1))
                        begin
                            st_next = ST_NOT_EXCL;
                        end
                        else
                        begin
                            ram_we            = 1'b1;
                            ram_wdata.passing = 1'b1;
                            res_next          = h_reg;
                        end
                    end
                    ACT_UNMARK:
                    begin
                        ram_we            = 1'b1;
                        ram_wdata.passing = 1'b0;
                        res_next          = h_reg;
                    end
                    default:
                    begin
                        state_next = S_AFF_RD;
                    end
                endcase
            end

            // Reuse pass: lowest occupied slot with no users and equal type and size.
            S_R_RD:
            begin
                if (idx_reg == CNT_W'(SLOTS))
                begin
                    idx_next   = '0;
                    state_next = S_EMPTY;
                end
                else if (occ_reg[cur])
                begin
                    ram_re     = 1'b1;
                    state_next = S_R_EV;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_R_EV:
            begin
                if (rd.users == '0 && rd.total == al_total_reg && rd.btype == al_type_reg)
                begin
                    ram_we     = 1'b1;
                    res_next   = HANDLE_W'(cur);
                    state_next = S_AFF_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_R_RD;
                end
            end

            // Empty pass: only the lowest empty slot is a candidate.
            S_EMPTY:
            begin
                if (idx_reg == CNT_W'(SLOTS))
                begin
                    state_next = S_E_RD;
                end
                else if (occ_reg[cur])
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (fits)
                begin
                    ram_we        = 1'b1;
                    occ_next[cur] = 1'b1;
                    bytes_next    = sum[BYTES_W-1:0];
                    live_next     = live_reg + CNT_W'(1);
                    res_next      = HANDLE_W'(cur);
                    state_next    = S_AFF_RD;
                end
                else
                begin
                    idx_next   = CNT_W'(SLOTS);
                    state_next = S_E_RD;
                end
            end

            // Eviction pass from the top; the slot checked is idx_reg - 1.
            S_E_RD:
            begin
                ram_raddr = down;
                if (idx_reg == '0)
                begin
                    st_next    = ST_NO_MEMORY;
                    state_next = S_AFF_RD;
                end
                else if (occ_reg[down])
                begin
                    ram_re     = 1'b1;
                    state_next = S_E_EV;
                end
                else
                begin
                    idx_next = idx_dn;
                end
            end

            S_E_EV:
            begin
                if (rd.users == '0)
                begin
                    bytes_next     = bytes_reg - BYTES_W'(rd.total);
                    live_next      = live_reg - CNT_W'(1);
                    occ_next[down] = 1'b0;
                    freed_next     = freed_reg + 6'd1;
                    state_next     = S_E_FIT;
                end
                else
                begin
                    idx_next   = idx_dn;
                    state_next = S_E_RD;
                end
            end

            S_E_FIT:
            begin
                ram_waddr = down;
                if (fits)
                begin
                    ram_we         = 1'b1;
                    occ_next[down] = 1'b1;
                    bytes_next     = sum[BYTES_W-1:0];
                    live_next      = live_reg + CNT_W'(1);
                    res_next       = HANDLE_W'(down);
                    state_next     = S_AFF_RD;
                end
                else
                begin
                    idx_next   = idx_dn;
                    state_next = S_E_RD;
                end
            end

            S_COL_RD:
            begin
                if (idx_reg == CNT_W'(SLOTS))
                begin
                    state_next = S_AFF_RD;
                end
                else if (occ_reg[cur])
                begin
                    ram_re     = 1'b1;
                    state_next = S_COL_EV;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_COL_EV:
            begin
                if (rd.users == '0)
                begin
                    bytes_next    = bytes_reg - BYTES_W'(rd.total);
                    live_next     = live_reg - CNT_W'(1);
                    occ_next[cur] = 1'b0;
                    freed_next    = freed_reg + 6'd1;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_COL_RD;
            end

            // Read back the affected slot for the user count.
            S_AFF_RD:
            begin
                if (res_reg != NO_SLOT)
                begin
                    aff = res_reg;
                end
                else if (h_valid)
                begin
                    aff = h_reg;
                end
                ram_raddr = aff[SLOT_W-1:0];
                if (aff != NO_SLOT)
                begin
                    ram_re     = 1'b1;
                    state_next = S_AFF_EV;
                end
                else
                begin
                    users_next = '0;
                    state_next = S_DONE;
                end
            end

            S_AFF_EV:
            begin
                users_next = rd.users;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            act_reg      <= ACT_NEW;
            h_reg        <= NO_SLOT;
            al_type_reg  <= '0;
            al_total_reg <= '0;
            is_copy_reg  <= 1'b0;
            st_reg       <= ST_OK;
            res_reg      <= NO_SLOT;
            freed_reg    <= '0;
            rel_reg      <= 1'b0;
            users_reg    <= '0;
            bytes_reg    <= '0;
            live_reg     <= '0;
            occ_reg      <= '0;
            limit_reg    <= '1;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            act_reg      <= act_next;
            h_reg        <= h_next;
            al_type_reg  <= al_type_next;
            al_total_reg <= al_total_next;
            is_copy_reg  <= is_copy_next;
            st_reg       <= st_next;
            res_reg      <= res_next;
            freed_reg    <= freed_next;
            rel_reg      <= rel_next;
            users_reg    <= users_next;
            bytes_reg    <= bytes_next;
            live_reg     <= live_next;
            occ_reg      <= occ_next;
            if (byte_limit_we)
            begin
                limit_reg <= byte_limit;
            end
        end
    end

    // Result register; the next item may start while it waits for a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid      <= 1'b0;
            status         <= ST_OK;
            result_handle  <= NO_SLOT;
            users_left     <= '0;
            writable       <= 1'b0;
            owner_released <= 1'b0;
            copy_from      <= NO_SLOT;
            freed_count    <= '0;
            bytes_in_use   <= '0;
            live_buffers   <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (state_reg == S_DONE && (!out_valid || out_ready))
            begin
                out_valid      <= 1'b1;
                status         <= st_reg;
                result_handle  <= res_reg;
                users_left     <= users_reg;
                writable       <= (users_reg == USERS_W'(1));
                owner_released <= rel_reg;
                copy_from      <= (is_copy_reg && res_reg != NO_SLOT) ? h_reg : NO_SLOT;
                freed_count    <= freed_reg;
                bytes_in_use   <= bytes_reg;
                live_buffers   <= 6'(live_reg);
            end
        end
    end

    `RBSM_ASSERT_SAME(a_live_matches_occ, 1'b1, $countones(occ_reg) == 32'(live_reg), "live count differs from occupied slots")
    `RBSM_ASSERT_SAME(a_no_rw_overlap, ram_we && ram_re, ram_waddr != ram_raddr, "slot RAM read and write hit the same entry")
    `RBSM_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg != S_IDLE, "accepted item did not start")

endmodule

`default_nettype wire

FILE: hdl/rbsm_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module rbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: tb/refcounted_buffer_slot_manager_unit_test.sv
// ============================================================================
// Buffer slot manager testbench
// Drives actions through the valid/ready input channel and predicts every
// result with an internal model of the slot table, the byte budget and
// the eviction order. Results are compared field by field in order. The run
// covers several byte limits, random idling on both sides, a long output
// stall, and a user count raised by a run of copies.
// ============================================================================
`default_nettype none

module refcounted_buffer_slot_manager_unit_test;
    import rbsm_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 250;
    localparam int HOLD_CYCLES     = 400;

    typedef struct packed {
        logic [3:0]          status;
        logic [HANDLE_W-1:0] result_handle;
        logic [USERS_W-1:0]  users_left;
        logic                writable;
        logic                owner_released;
        logic [HANDLE_W-1:0] copy_from;
        logic [5:0]          freed_count;
        logic [BYTES_W-1:0]  bytes_in_use;
        logic [5:0]          live_buffers;
    } slot_result_t;

    // Pool model and the queue of results it predicts.
    class slot_pool_scoreboard;
        logic [31:0]  limit;
        bit           occ[SLOTS];
        logic [15:0]  btype[SLOTS];
        logic [31:0]  total[SLOTS];
        logic [31:0]  users[SLOTS];
        bit           passing[SLOTS];
        logic [31:0]  used;
        int           live;
        int           last_res;
        int           errors;
        slot_result_t pending_results[$];

        function new();
            limit = '1;
            used = 0;
            live = 0;
            errors = 0;
            last_res = -1;
            foreach (occ[i])
            begin
                occ[i] = 0;
                users[i] = 0;
                passing[i] = 0;
                total[i] = 0;
                btype[i] = 0;
            end
        endfunction

        function bit fits(logic [31:0] t);
            longint cap;
            cap = (limit != 0) ? longint'(limit) : 64'hFFFF_FFFF;
            return longint'(used) + longint'(t) <= cap;
        endfunction

        function void place(int i, logic [15:0] ty, logic [31:0] t);
            occ[i] = 1;
            btype[i] = ty;
            total[i] = t;
            users[i] = 1;
            passing[i] = 0;
            used = used + t;
            live++;
        endfunction

        function void drop(int i);
            used = used - total[i];
            live--;
            occ[i] = 0;
            passing[i] = 0;
            users[i] = 0;
        endfunction

        function int grant(logic [15:0] ty, logic [31:0] t, bit reuse, inout int freed);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (reuse && occ[i] && users[i] == 0 && total[i] == t && btype[i] == ty)
                begin
                    users[i] = 1;
                    passing[i] = 0;
                    return i;
                end
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!occ[i])
                begin
                    if (fits(t))
                    begin
                        place(i, ty, t);
                        return i;
                    end
                    break;
                end
            end
            // Evict unused slots from the top down until the buffer fits.
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (occ[i] && users[i] == 0)
                begin
                    drop(i);
                    freed++;
                    if (fits(t))
                    begin
                        place(i, ty, t);
                        return i;
                    end
                end
            end
            return -1;
        endfunction

        function void note_input(logic [3:0] act, logic [5:0] hraw, logic [15:0] ty,
                                 logic [23:0] db);
            int h;
            bit ok;
            logic [3:0] st;
            int res;
            int src;
            int aff;
            int freed;
            bit rel;
            logic [31:0] u;
            slot_result_t r;
            h = $signed(hraw);
            ok = h >= 0 && h < SLOTS && occ[h >= 0 && h < SLOTS ? h : 0];
            st = ST_OK;
            res = -1;
            src = -1;
            freed = 0;
            rel = 0;
            u = 0;
            case (act)
                ACT_NEW, ACT_BRANDNEW:
                begin
                    res = grant(ty, 32'(db) + HEADER_BYTES, act == ACT_NEW, freed);
                    if (res < 0) st = ST_NO_MEMORY;
                end
                ACT_COPY_RO:
                begin
                    if (!ok) st = ST_BAD_HANDLE;
                    else if (users[h] == 0) st = ST_ZERO_USERS;
                    else if (passing[h])
                    begin
                        passing[h] = 0;
                        rel = 1;
                        res = h;
                    end
                    else if (users[h] >= 32'hFFFF) st = ST_SATURATED;
                    else
                    begin
                        users[h]++;
                        res = h;
                    end
                end
                ACT_COPY_RW:
                begin
                    if (!ok) st = ST_BAD_HANDLE;
                    else if (users[h] == 0) st = ST_ZERO_USERS;
                    else if (passing[h])
                    begin
                        passing[h] = 0;
                        rel = 1;
                        res = h;
                    end
                    else
                    begin
                        res = grant(btype[h], total[h], 1, freed);
                        if (res < 0) st = ST_NO_MEMORY;
                        else src = h;
                    end
                end
                ACT_CLONE:
                begin
                    if (!ok) st = ST_BAD_HANDLE;
                    else
                    begin
                        res = grant(btype[h], total[h], 1, freed);
                        if (res < 0) st = ST_NO_MEMORY;
                    end
                end
                ACT_UNUSED, ACT_DELETE:
                begin
                    if (!ok) st = (h == -1) ? ST_OK : ST_BAD_HANDLE;
                    else
                    begin
                        if (passing[h]) st = ST_PASS_IGN;
                        else if (users[h] == 0) st = ST_ZERO_USERS;
                        else users[h]--;
                        if (act == ACT_UNUSED)
                        begin
                            if (st == ST_OK) res = h;
                        end
                        else if (users[h] == 0)
                        begin
                            drop(h);
                            freed = 1;
                            st = ST_OK;
                        end
                        else st = ST_USERS_LEFT;
                    end
                end
                ACT_MARK_PASS:
                begin
                    if (!ok) st = ST_BAD_HANDLE;
                    else if (passing[h]) st = ST_DUP_PASS;
                    else if (users[h] != 1) st = ST_NOT_EXCL;
                    else
                    begin
                        passing[h] = 1;
                        res = h;
                    end
                end
                ACT_UNMARK:
                begin
                    if (!ok) st = ST_BAD_HANDLE;
                    else
                    begin
                        passing[h] = 0;
                        res = h;
                    end
                end
                ACT_COLLECT:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (occ[i] && users[i] == 0)
                        begin
                            drop(i);
                            freed++;
                        end
                    end
                end
                default: ;
            endcase
            aff = res;
            if (aff < 0 && h >= 0 && h < SLOTS && occ[h]) aff = h;
            if (aff >= 0 && occ[aff]) u = users[aff];
            last_res = res;
            r.status = st;
            r.result_handle = HANDLE_W'(res);
            r.users_left = u[15:0];
            r.writable = (aff >= 0 && occ[aff] && u == 1);
            r.owner_released = rel;
            r.copy_from = HANDLE_W'(src);
            r.freed_count = 6'(freed);
            r.bytes_in_use = used;
            r.live_buffers = 6'(live);
            pending_results.push_back(r);
        endfunction

        function void check_result(slot_result_t got);
            slot_result_t e;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result: status %0d", got.status);
                return;
            end
            e = pending_results.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected st %0d rh %0d u %0d w %0d rel %0d cf %0d ",
                              "fr %0d by %0d lv %0d, got st %0d rh %0d u %0d w %0d rel %0d ",
                              "cf %0d fr %0d by %0d lv %0d"},
                             e.status, e.result_handle, e.users_left, e.writable,
                             e.owner_released, e.copy_from, e.freed_count, e.bytes_in_use,
                             e.live_buffers, got.status, got.result_handle, got.users_left,
                             got.writable, got.owner_released, got.copy_from,
                             got.freed_count, got.bytes_in_use, got.live_buffers);
            end
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                byte_limit_we = 0;
    logic [BYTES_W-1:0]  byte_limit = '1;
    logic                in_valid = 0;
    logic                in_ready;
    logic [3:0]          action = ACT_COLLECT;
    logic [HANDLE_W-1:0] handle = NO_SLOT;
    logic [TYPE_W-1:0]   buffer_type = 0;
    logic [DATA_W-1:0]   data_bytes = 0;
    logic                out_valid;
    logic                out_ready = 0;
    slot_result_t        got;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 0;
    int quiet_cycles = 0;
    slot_pool_scoreboard pool;

    refcounted_buffer_slot_manager_unit dut (
        .clk(clk), .rst_n(rst_n),
        .byte_limit_we(byte_limit_we), .byte_limit(byte_limit),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .handle(handle), .buffer_type(buffer_type),
        .data_bytes(data_bytes),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(got.status), .result_handle(got.result_handle),
        .users_left(got.users_left), .writable(got.writable),
        .owner_released(got.owner_released), .copy_from(got.copy_from),
        .freed_count(got.freed_count), .bytes_in_use(got.bytes_in_use),
        .live_buffers(got.live_buffers)
    );

    always #5 clk = ~clk;

    // Receiver with random stalls and an occasional long hold-off.
    initial
    begin
        int hold;
        pool = new();
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) pool.check_result(got);
            if (hold_req && hold == 0) hold = HOLD_CYCLES;
            if (hold > 0)
            begin
                hold--;
                if (hold == 0) hold_req = 0;
                out_ready <= 0;
            end
            else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Leaves in_valid high after the transfer so that a following item
    // can be offered in the same step without lowering it.
    task automatic send(logic [3:0] act, logic [5:0] h, logic [15:0] ty, logic [23:0] db);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        handle <= h;
        buffer_type <= ty;
        data_bytes <= db;
        do @(posedge clk); while (!in_ready);
        pool.note_input(act, h, ty, db);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pool.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(logic [31:0] v);
        byte_limit_we <= 1;
        byte_limit <= v;
        @(posedge clk);
        byte_limit_we <= 0;
        pool.limit = v;
    endtask

    function automatic logic [5:0] pick_handle();
        int cand[$];
        for (int i = 0; i < SLOTS; i++)
            if (pool.occ[i]) cand.push_back(i);
        if (cand.size() != 0 && $urandom_range(0, 99) < 85)
            return 6'(cand[$urandom_range(0, cand.size() - 1)]);
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic send_random();
        int r;
        logic [3:0] act;
        logic [15:0] ty;
        logic [23:0] db;
        r = $urandom_range(0, 99);
        if (r < 22) act = ACT_NEW;
        else if (r < 30) act = ACT_BRANDNEW;
        else if (r < 38) act = ACT_COPY_RO;
        else if (r < 45) act = ACT_COPY_RW;
        else if (r < 50) act = ACT_CLONE;
        else if (r < 66) act = ACT_UNUSED;
        else if (r < 76) act = ACT_DELETE;
        else if (r < 84) act = ACT_MARK_PASS;
        else if (r < 90) act = ACT_UNMARK;
        else if (r < 96) act = ACT_COLLECT;
        else act = 4'($urandom_range(10, 15));
        case ($urandom_range(0, 5))
            0: ty = 0;
            1: ty = '1;
            2: ty = 16'($urandom);
            default: ty = 16'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 9))
            0: db = '1;
            1: db = 24'($urandom);
            2: db = 0;
            default: db = 24'($urandom_range(0, 3) * 100);
        endcase
        send(act, pick_handle(), ty, db);
    endtask

    initial
    begin
        int h0;
        int h1;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: extremes and the special cases of each action.
        send(ACT_NEW, NO_SLOT, '1, '1);
        h0 = pool.last_res;
        send(ACT_NEW, NO_SLOT, 0, 0);
        h1 = pool.last_res;
        send(ACT_BRANDNEW, NO_SLOT, 16'h5A5A, 24'h00A5A5);
        send(ACT_COPY_RW, 6'(h0), 0, 0);
        send(ACT_CLONE, 6'(h1), 0, 0);
        send(ACT_MARK_PASS, 6'(h1), 0, 0);
        send(ACT_MARK_PASS, 6'(h1), 0, 0);
        send(ACT_UNUSED, 6'(h1), 0, 0);
        send(ACT_DELETE, 6'(h1), 0, 0);
        send(ACT_COPY_RO, 6'(h1), 0, 0);
        send(ACT_MARK_PASS, 6'(h1), 0, 0);
        send(ACT_COPY_RW, 6'(h1), 0, 0);
        send(ACT_UNMARK, 6'(h1), 0, 0);
        send(ACT_UNUSED, 6'(h1), 0, 0);
        send(ACT_UNUSED, 6'(h1), 0, 0);
        send(ACT_COPY_RO, 6'(h1), 0, 0);
        send(ACT_DELETE, 6'(h1), 0, 0);
        send(ACT_UNUSED, 6'(h0), 0, 0);
        send(ACT_NEW, NO_SLOT, '1, '1);
        send(ACT_UNUSED, NO_SLOT, 0, 0);
        send(ACT_DELETE, NO_SLOT, 0, 0);
        send(ACT_COPY_RO, 6'd31, 0, 0);
        send(ACT_UNMARK, 6'h20, 0, 0);
        send(4'd15, 6'd5, 0, 0);
        send(ACT_COLLECT, NO_SLOT, 0, 0);

        // Raise one slot's user count by a run of copies.
        send(ACT_BRANDNEW, NO_SLOT, 16'h0077, 24'd1);
        h0 = pool.last_res;
        repeat (20) send(ACT_COPY_RO, 6'(h0), 0, 0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_limit('1);
                1: set_limit(0);
                2: set_limit(32'd2000);
                3: set_limit(32'd700);
                4: set_limit($urandom_range(0, 20000));
                default: set_limit(32'd64);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (p == 2) hold_req = 1;
            repeat (75) send_random();
            drain();
        end
        set_limit('1);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        repeat (20) send_random();
        drain();

        if (pool.errors == 0 && pool.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
